@@ design/ctss_pkg.sv @@
// ---------------------------------------------------------------------------
// Clock time serializer package
// Shared constants, frame types and the segment lookup for the serializer.
// ---------------------------------------------------------------------------
package ctss_pkg;

    localparam int HOURS_W     = 5;
    localparam int MINUTES_W   = 6;
    localparam int SEG_W       = 8;
    localparam int FRAME_BITS  = 4 * SEG_W;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int DP_BIT      = 1;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    // Reciprocal of ten for values below 64: tens = (v * 205) >> 11.
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [SEG_W-1:0]      seg_t;
    typedef logic [3:0]            digit_t;

    function automatic seg_t seg_of(input digit_t digit);
        seg_t seg;
        case (digit)
            4'd0:    seg = 8'h42;
            4'd1:    seg = 8'hDE;
            4'd2:    seg = 8'h83;
            4'd3:    seg = 8'h8A;
            4'd4:    seg = 8'h1E;
            4'd5:    seg = 8'h2A;
            4'd6:    seg = 8'h22;
            4'd7:    seg = 8'hCE;
            4'd8:    seg = 8'h02;
            4'd9:    seg = 8'h0A;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

@@ design/ctss_front.sv @@
// ---------------------------------------------------------------------------
// Clock time serializer front end
// Splits hours and minutes into digits and builds the 32-bit segment frame.
// ---------------------------------------------------------------------------
module ctss_front (
    input  logic [ctss_pkg::HOURS_W-1:0]   hours,
    input  logic [ctss_pkg::MINUTES_W-1:0] minutes,
    input  logic                           is_pm,
    input  logic                           alarm_on,
    output ctss_pkg::frame_t               frame
);
    import ctss_pkg::*;

    localparam int PROD_W = MINUTES_W + 8;

    logic [PROD_W-1:0] min_prod;
    logic [PROD_W-1:0] hr_prod;
    digit_t            min_tens;
    digit_t            min_ones;
    digit_t            hr_tens;
    digit_t            hr_ones;
    seg_t              seg_min_ones;
    seg_t              seg_min_tens;
    seg_t              seg_hr_ones;
    seg_t              seg_hr_tens;

    always_comb begin
        min_prod = PROD_W'(minutes) * PROD_W'(DIV10_MUL);
        hr_prod  = PROD_W'(hours) * PROD_W'(DIV10_MUL);
        min_tens = 4'(min_prod >> DIV10_SHIFT);
        hr_tens  = 4'(hr_prod >> DIV10_SHIFT);
        min_ones = 4'(minutes - MINUTES_W'(min_tens) * MINUTES_W'(10));
        hr_ones  = 4'(hours - HOURS_W'(hr_tens) * HOURS_W'(10));

        seg_min_ones = seg_of(min_ones);
        seg_min_tens = seg_of(min_tens);
        seg_hr_ones  = seg_of(hr_ones);
        seg_hr_tens  = (hr_tens == 4'd0) ? SEG_BLANK : seg_of(hr_tens);

        if (is_pm) begin
            seg_min_ones[DP_BIT] = 1'b0;
        end
        if (alarm_on) begin
            seg_hr_ones[DP_BIT] = 1'b0;
        end

        frame = {seg_hr_tens, seg_hr_ones, seg_min_tens, seg_min_ones};
    end

endmodule

@@ design/ctss_queue.sv @@
// ---------------------------------------------------------------------------
// Clock time serializer frame queue
// Small register queue that decouples frame building from shifting.
// ---------------------------------------------------------------------------
module ctss_queue #(
    parameter int DEPTH = ctss_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  ctss_pkg::frame_t wr_data,
    output logic             rd_valid,
    input  logic             rd_en,
    output ctss_pkg::frame_t rd_data
);
    import ctss_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             mem_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds its depth.");
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Queue count did not follow a write.");
`endif

endmodule

@@ design/ctss_back.sv @@
// ---------------------------------------------------------------------------
// Clock time serializer back end
// Shifts each queued frame out one bit per request, LSB first.
// ---------------------------------------------------------------------------
module ctss_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_valid,
    output logic             rd_en,
    input  ctss_pkg::frame_t rd_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_serial_bit,
    output logic             m_last
);
    import ctss_pkg::*;

    frame_t                 shift_reg;
    frame_t                 shift_next;
    logic [BIT_CNT_W-1:0]   cnt_reg;
    logic [BIT_CNT_W-1:0]   cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   load;
    logic                   at_last;

    assign at_last      = (cnt_reg == BIT_CNT_W'(FRAME_BITS - 1));
    assign m_valid      = busy_reg;
    assign m_serial_bit = shift_reg[0];
    assign m_last       = busy_reg && at_last;
    assign load         = rd_valid && (!busy_reg || (m_ready && at_last));
    assign rd_en        = load;

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load) begin
            shift_next = rd_data;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                shift_next = shift_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

`ifndef NO_ASSERTIONS
    a_mid_frame_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("Output dropped in the middle of a frame.");
    a_stall_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(cnt_reg))
        else $error("Bit counter moved while the output was stalled.");
    a_load_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && busy_reg) |-> (m_ready && at_last))
        else $error("New frame loaded before the current one finished.");
`endif

endmodule

@@ design/clock_time_to_segment_serializer.sv @@
// ---------------------------------------------------------------------------
// Clock time to segment serializer
// Converts a time of day to four active-low segment bytes and shifts them out.
// ---------------------------------------------------------------------------
//  Channel  Direction  Ports                                     Carries
//  s_       in         s_valid s_ready s_hours s_minutes         one time request
//                      s_is_pm s_alarm_on
//  m_       out        m_valid m_ready m_serial_bit m_last       one bit per request
//
//  Each time request gives 32 output bits, shifted out by the output shift register
//  one per cycle while m_ready is high.
//  A request is encoded in the cycle it is accepted and written to a two-entry
//  frame queue; the shifter loads the next frame in the cycle the last bit goes,
//  so consecutive frames stream without a gap.
//  s_ready stays high while the queue has room, so input and output stall apart.
//  Reset empties the queue and idles the shifter.
// ---------------------------------------------------------------------------
module clock_time_to_segment_serializer #(
    parameter int QUEUE_DEPTH = ctss_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ctss_pkg::HOURS_W-1:0]   s_hours,
    input  logic [ctss_pkg::MINUTES_W-1:0] s_minutes,
    input  logic                           s_is_pm,
    input  logic                           s_alarm_on,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_serial_bit,
    output logic                           m_last
);
    import ctss_pkg::*;

    frame_t front_frame;
    frame_t queue_data;
    logic   queue_valid;
    logic   queue_rd_en;

    ctss_front u_front (
        .hours    (s_hours),
        .minutes  (s_minutes),
        .is_pm    (s_is_pm),
        .alarm_on (s_alarm_on),
        .frame    (front_frame)
    );

    ctss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_frame),
        .rd_valid (queue_valid),
        .rd_en    (queue_rd_en),
        .rd_data  (queue_data)
    );

    ctss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_valid     (queue_valid),
        .rd_en        (queue_rd_en),
        .rd_data      (queue_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_serial_bit (m_serial_bit),
        .m_last       (m_last)
    );

endmodule
